// ===== rtl/core/swap_slot_bitmap_allocator_top_macros.svh =====
// assertion macros for the swap slot bitmap allocator
// used by swap_slot_bitmap_allocator_top; expects clk and rst_n in scope
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SSBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SSBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ssba_pkg.sv =====
// shared types and constants for the swap slot bitmap allocator
// no dependencies
package ssba_pkg;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int WORD_BITS_DEF = 32;

    localparam int SLOT_W   = 10;
    localparam int ACTIVE_W = 6;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd32;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic {
        REG_ACTIVE_WORDS = 1'b0
    } reg_index_t;

endpackage

// ===== rtl/core/swap_slot_bitmap_allocator_top.sv =====
// swap slot bitmap allocator: first-fit allocate and free over a word-wide bitmap ram
// depends on ssba_pkg and swap_slot_bitmap_allocator_top_macros.svh
// allocate: first-fit scan from word 0 over the active words, one bitmap word read per cycle
// free: word search by repeated add of WORD_BITS, then read-modify-write
// no active word: idle answers either kind; one transaction at a time, result held until taken
// reset: async, active low; a clearing pass over all NUM_WORDS words zeroes the bitmap, req_stall high
`include "swap_slot_bitmap_allocator_top_macros.svh"

module swap_slot_bitmap_allocator_top
    import ssba_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               req_valid,
    output logic               req_stall,
    input  logic               kind,
    input  logic [SLOT_W-1:0]  slot_index,

    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [SLOT_W-1:0]  slot,
    output logic [1:0]         status
);

    localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CW        = $clog2(NUM_WORDS + 1);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int BASE_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
    localparam int CMP_W     = ((BASE_W > SLOT_W) ? BASE_W : SLOT_W) + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FSRCH,
        S_FCLR
    } state_t;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 we;
    logic [AW-1:0]        wa;
    logic [WORD_BITS-1:0] wd;

    state_t              state_reg, state_next;
    logic [AW-1:0]       w_reg, w_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [BW-1:0]       bit_reg, bit_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [ACTIVE_W-1:0] active_reg, active_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    status_t             status_reg, status_next;

    logic [CW-1:0]        eff_words;
    logic [CW-1:0]        w_plus1;
    logic                 last_word;
    logic [WORD_BITS-1:0] inv_word;
    logic [WORD_BITS-1:0] low_zero;
    logic [BW-1:0]        enc;
    logic [CMP_W-1:0]     idx_ext;
    logic [CMP_W-1:0]     base_ext;
    logic [CMP_W-1:0]     limit;
    logic                 req_fire;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ACTIVE_WORDS) ?
                       PDATA_W'(active_reg) : '0;

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign req_fire  = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign slot      = slot_reg;
    assign status    = status_reg;

    assign eff_words = (32'(active_reg) > NUM_WORDS) ? CW'(NUM_WORDS) : CW'(active_reg);
    assign w_plus1   = CW'(w_reg) + CW'(1);
    assign last_word = (w_plus1 >= eff_words);

    assign inv_word  = ~rd_data_reg;
    assign low_zero  = inv_word & (rd_data_reg + WORD_BITS'(1));

    assign idx_ext   = CMP_W'(idx_reg);
    assign base_ext  = CMP_W'(base_reg);
    assign limit     = base_ext + CMP_W'(WORD_BITS);

    always_comb
    begin
        enc = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (low_zero[i])
            begin
                enc = enc | BW'(i);
            end
        end
    end

    // read address and write port
    always_comb
    begin
        rd_addr = w_reg;
        we      = 1'b0;
        wa      = w_reg;
        wd      = rd_data_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wd = '0;
            end
            S_IDLE:
            begin
                rd_addr = '0;
            end
            S_SCAN:
            begin
                if (32'(w_reg) < NUM_WORDS - 1)
                begin
                    rd_addr = w_reg + AW'(1);
                end
                if (inv_word != '0)
                begin
                    we = 1'b1;
                    wd = rd_data_reg | low_zero;
                end
            end
            S_FSRCH:
            begin
                rd_addr = w_reg;
            end
            S_FCLR:
            begin
                we = 1'b1;
                wd = rd_data_reg & ~(WORD_BITS'(1) << bit_reg);
            end
            default:
            begin
                rd_addr = w_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        base_next      = base_reg;
        bit_next       = bit_reg;
        idx_next       = idx_reg;
        active_next    = active_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        slot_next      = slot_reg;
        status_next    = status_reg;

        if (cfg_write && (paddr[2] == REG_ACTIVE_WORDS))
        begin
            active_next = pwdata[ACTIVE_W-1:0];
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                if (32'(w_reg) == NUM_WORDS - 1)
                begin
                    w_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next = w_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    w_next    = '0;
                    base_next = '0;
                    idx_next  = slot_index;
                    if (eff_words == '0)
                    begin
                        rsp_valid_next = 1'b1;
                        if (kind == KIND_ALLOC)
                        begin
                            slot_next   = '0;
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            slot_next   = slot_index;
                            status_next = ST_RANGE;
                        end
                    end
                    else if (kind == KIND_ALLOC)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FSRCH;
                    end
                end
            end
            S_SCAN:
            begin
                if (inv_word != '0)
                begin
                    rsp_valid_next = 1'b1;
                    slot_next      = SLOT_W'(base_ext + CMP_W'(enc));
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                end
                else if (last_word)
                begin
                    rsp_valid_next = 1'b1;
                    slot_next      = '0;
                    status_next    = ST_FULL;
                    state_next     = S_IDLE;
                end
                else
                begin
                    w_next    = w_reg + AW'(1);
                    base_next = base_reg + BASE_W'(WORD_BITS);
                end
            end
            S_FSRCH:
            begin
                if (idx_ext < limit)
                begin
                    bit_next   = BW'(idx_ext - base_ext);
                    state_next = S_FCLR;
                end
                else if (last_word)
                begin
                    rsp_valid_next = 1'b1;
                    slot_next      = idx_reg;
                    status_next    = ST_RANGE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    w_next    = w_reg + AW'(1);
                    base_next = base_reg + BASE_W'(WORD_BITS);
                end
            end
            S_FCLR:
            begin
                rsp_valid_next = 1'b1;
                slot_next      = idx_reg;
                status_next    = ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            w_reg         <= '0;
            active_reg    <= ACTIVE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        bit_reg    <= bit_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
    end

    `SSBA_ASSERT_SAME(a_no_result_while_busy,
        (state_reg == S_SCAN || state_reg == S_FSRCH || state_reg == S_FCLR),
        !rsp_valid_reg, "result register occupied during a transaction")

    `SSBA_ASSERT_SAME(a_word_in_range,
        (state_reg == S_SCAN || state_reg == S_FSRCH),
        (CW'(w_reg) < eff_words), "word index beyond active words")

    `SSBA_ASSERT_SAME(a_full_slot_zero,
        (rsp_valid_reg && status_reg == ST_FULL), (slot_reg == '0),
        "full result with nonzero slot")

    `SSBA_ASSERT_NEXT(a_free_clear_finishes,
        (state_reg == S_FCLR), (rsp_valid_reg && status_reg == ST_OK && slot_reg == $past(idx_reg)),
        "free did not complete with echoed index")

endmodule

// ===== dv/swap_slot_bitmap_allocator_checker.sv =====
// scoreboard for the swap slot bitmap allocator: first-fit prediction on a local bitmap copy
// depends on ssba_pkg; watches the apb write port and both handshake channels
module swap_slot_bitmap_allocator_checker
    import ssba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,

    input  logic               req_valid,
    input  logic               req_stall,
    input  logic               kind,
    input  logic [SLOT_W-1:0]  slot_index,

    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [1:0]         status,

    output int                 mismatches,
    output int                 outstanding,
    output int                 full_count,
    output int                 range_count
);

    localparam int WORD_BITS = WORD_BITS_DEF;
    localparam int NUM_WORDS = (MAX_SLOTS_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } slot_result_t;

    logic [WORD_BITS-1:0] slot_map [NUM_WORDS];
    logic [ACTIVE_W-1:0]  active_words;
    slot_result_t         slot_results_due [$];

    function automatic slot_result_t first_fit_result(input kind_t k,
                                                      input logic [SLOT_W-1:0] idx);
        slot_result_t r;
        int words;
        int w;
        int b;
        r.slot   = '0;
        r.status = ST_FULL;
        words = (int'(active_words) > NUM_WORDS) ? NUM_WORDS : int'(active_words);
        if (k == KIND_ALLOC) begin
            for (w = 0; w < words && r.status == ST_FULL; w++) begin
                for (b = 0; b < WORD_BITS && r.status == ST_FULL; b++) begin
                    if (!slot_map[w][b]) begin
                        slot_map[w][b] = 1'b1;
                        r.slot   = SLOT_W'(w * WORD_BITS + b);
                        r.status = ST_OK;
                    end
                end
            end
        end
        else begin
            r.slot = idx;
            if (int'(idx) >= words * WORD_BITS) begin
                r.status = ST_RANGE;
            end
            else begin
                slot_map[int'(idx) / WORD_BITS][int'(idx) % WORD_BITS] = 1'b0;
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        slot_result_t want;
        if (!rst_n) begin
            foreach (slot_map[i]) begin
                slot_map[i] = '0;
            end
            active_words = ACTIVE_RESET;
            slot_results_due.delete();
            mismatches  = 0;
            full_count  = 0;
            range_count = 0;
            outstanding <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
                    && paddr[PADDR_W-1:2] == REG_ACTIVE_WORDS) begin
                active_words = pwdata[ACTIVE_W-1:0];
            end
            if (rsp_valid && !rsp_stall) begin
                if (slot_results_due.size() == 0) begin
                    $error("unexpected transaction: slot %0d status %0d", slot, status);
                    mismatches++;
                end
                else begin
                    want = slot_results_due.pop_front();
                    if (slot !== want.slot) begin
                        $error("slot mismatch: expected %0d, actual %0d", want.slot, slot);
                        mismatches++;
                    end
                    if (status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                        mismatches++;
                    end
                    if (want.status == ST_FULL) begin
                        full_count++;
                    end
                    if (want.status == ST_RANGE) begin
                        range_count++;
                    end
                end
            end
            if (req_valid && !req_stall) begin
                slot_results_due.push_back(first_fit_result(kind_t'(kind), slot_index));
            end
            outstanding <= slot_results_due.size();
        end
    end

endmodule

// ===== dv/tb_swap_slot_bitmap_allocator_top.sv =====
// testbench top for swap_slot_bitmap_allocator_top: directed and random allocate/free traffic
// depends on ssba_pkg, swap_slot_bitmap_allocator_top and swap_slot_bitmap_allocator_checker
module tb_swap_slot_bitmap_allocator_top;
    import ssba_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_ACTIVE_WORDS = PADDR_W'(4 * REG_ACTIVE_WORDS);
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED     = ADDR_ACTIVE_WORDS + PADDR_W'(4);
    localparam int NUM_WORDS    = MAX_SLOTS_DEF / WORD_BITS_DEF;
    localparam int PHASE_ITEMS  = 119;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               req_valid;
    logic               req_stall;
    logic               kind;
    logic [SLOT_W-1:0]  slot_index;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [SLOT_W-1:0]  slot;
    logic [1:0]         status;

    int mismatches;
    int outstanding;
    int full_count;
    int range_count;
    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int settings_used = 0;

    always #1 clk = ~clk;

    swap_slot_bitmap_allocator_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .kind       (kind),
        .slot_index (slot_index),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .slot       (slot),
        .status     (status)
    );

    swap_slot_bitmap_allocator_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .kind        (kind),
        .slot_index  (slot_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .slot        (slot),
        .status      (status),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .full_count  (full_count),
        .range_count (range_count)
    );

    always @(posedge clk) begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_item(input kind_t k, input logic [SLOT_W-1:0] idx);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        kind       <= k;
        slot_index <= idx;
        @(posedge clk);
        while (req_stall) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic logic [SLOT_W-1:0] pick_free_index(input int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && span > 0) begin
            return SLOT_W'($urandom_range(0, span - 1));
        end
        if (r < 80) begin
            return SLOT_W'($urandom_range(0, 127));
        end
        return SLOT_W'($urandom);
    endfunction

    initial begin : stimulus
        int settings [16] = '{1, 2, 32, 0, 3, 63, 40, 32, 1, 8, 33, 2, 16, 32, 5, 1};
        logic [PDATA_W-1:0] wdata;
        int words;
        int span;
        int alloc_pct;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        req_valid  = 1'b0;
        kind       = KIND_ALLOC;
        slot_index = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: all words active
        send_item(KIND_ALLOC, SLOT_W'(1023));
        send_item(KIND_ALLOC, '0);
        send_item(KIND_ALLOC, SLOT_W'($urandom));
        send_item(KIND_FREE, SLOT_W'(1));
        send_item(KIND_ALLOC, SLOT_W'(512));
        send_item(KIND_FREE, SLOT_W'(1023));
        send_item(KIND_FREE, '0);
        send_item(KIND_FREE, '0);
        send_item(KIND_ALLOC, SLOT_W'(5));
        wait_drained();
        // write past the register list must not land
        apb_write(ADDR_UNMAPPED, '0);
        send_item(KIND_FREE, SLOT_W'(1000));
        wait_drained();
        // no active words
        apb_write(ADDR_ACTIVE_WORDS, '0);
        send_item(KIND_ALLOC, '0);
        send_item(KIND_FREE, '0);
        send_item(KIND_FREE, SLOT_W'(1023));
        wait_drained();
        apb_write(ADDR_ACTIVE_WORDS, 32'd1);
        send_item(KIND_FREE, SLOT_W'(31));
        send_item(KIND_FREE, SLOT_W'(32));
        send_item(KIND_ALLOC, '0);
        wait_drained();
        // above the word count, acts as all words
        apb_write(ADDR_ACTIVE_WORDS, 32'd63);
        send_item(KIND_FREE, SLOT_W'(1023));
        send_item(KIND_ALLOC, '0);
        wait_drained();
        apb_write(ADDR_ACTIVE_WORDS, 32'hFFFF_FFC2);
        send_item(KIND_FREE, SLOT_W'(63));
        send_item(KIND_FREE, SLOT_W'(64));
        wait_drained();

        for (int p = 0; p < 16; p++) begin
            if (p == 14) begin
                wdata = $urandom;
            end
            else begin
                wdata = ($urandom & 32'hFFFF_FFC0) | PDATA_W'(settings[p]);
            end
            apb_write(ADDR_ACTIVE_WORDS, wdata);
            words = int'(wdata[ACTIVE_W-1:0]);
            if (words > NUM_WORDS) begin
                words = NUM_WORDS;
            end
            span = words * WORD_BITS_DEF;
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            alloc_pct = $urandom_range(55, 85);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < alloc_pct) begin
                    send_item(KIND_ALLOC, SLOT_W'($urandom));
                end
                else begin
                    send_item(KIND_FREE, pick_free_index(span));
                end
            end
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();
        repeat (40) @(posedge clk);
        $display("ran %0d allocate/free transactions under %0d register writes",
                 items_sent, settings_used);
        $display("saw %0d full and %0d out-of-range results", full_count, range_count);
        if (mismatches == 0) begin
            $display("tb_swap_slot_bitmap_allocator_top: PASS");
        end
        else begin
            $display("tb_swap_slot_bitmap_allocator_top: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #1600000;
        $display("tb_swap_slot_bitmap_allocator_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ssba_pkg.sv
rtl/core/swap_slot_bitmap_allocator_top.sv
dv/swap_slot_bitmap_allocator_checker.sv
dv/tb_swap_slot_bitmap_allocator_top.sv
